@@ hw/rtl/eoa_pkg.sv @@
// shared types and codes for the event overlap accumulator
// no dependencies
package eoa_pkg;

    localparam int MAX_OPEN_DEF    = 8;
    localparam int NUM_CLASSES_DEF = 16;
    localparam int TAG_W           = 8;
    localparam int FIELD_CLASS_W   = 4;
    localparam int TIME_W          = 64;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_END      = 2'd1,
        CMD_RD_CELL  = 2'd2,
        CMD_RD_TOTAL = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
    localparam logic [1:0] STATUS_NO_END  = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [TAG_W-1:0]         event_tag;
        logic [FIELD_CLASS_W-1:0] event_class;
        logic [FIELD_CLASS_W-1:0] other_class;
        logic [TIME_W-1:0]        instant;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] overlap_added;
        logic [TIME_W-1:0] read_value;
        logic [TIME_W-1:0] total_time;
        logic [TIME_W-1:0] effective_time;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clr;
        logic slot_wr;
        logic hit_take;
        logic idx_clr;
        logic idx_inc;
        logic cell_rsel_slot;
        logic cls_rsel_hit;
        logic tot_wr;
        logic ov_take;
        logic ov_wr;
        logic rd_take;
        logic set_no_slot;
        logic set_no_end;
        logic res_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic idx_last;
        logic idx_valid;
        logic tag_hit;
        logic sweep_done;
    } stat_t;

endpackage

@@ hw/rtl/event_overlap_accumulator.sv @@
// event overlap accumulator: one result word per input word
// flow: an end scans the slots in turn for its tag, then runs an overlap pass over every
//   slot and adds to a cell for each open one; slots are read one at a time (slot memory port)
// throughput: one word at a time; a new word enters once the previous result is loaded
// reset: synchronous active-low; a clearing pass over NUM_CLASSES*NUM_CLASSES addresses
//   zeroes the overlap and class total memories before the first word is taken
module event_overlap_accumulator #(
    parameter int MAX_OPEN    = eoa_pkg::MAX_OPEN_DEF,
    parameter int NUM_CLASSES = eoa_pkg::NUM_CLASSES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  eoa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output eoa_pkg::out_t m_data
);
    import eoa_pkg::*;

    // command and status between sequencer and datapath
    ctrl_t ctrl;
    stat_t stat;

    // sequencer: clearing pass, slot write, reads, tag search, class total update, overlap pass
    eoa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // datapath: slot store, memories, running totals, output register
    eoa_datapath #(
        .MAX_OPEN    (MAX_OPEN),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_data  (m_data)
    );
endmodule

@@ hw/rtl/eoa_ram.sv @@
// generic simple dual-port ram, registered read
// no dependencies
module eoa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/eoa_ctrl.sv @@
// sequencing state machine for the event overlap accumulator
// depends on eoa_pkg
module eoa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  eoa_pkg::stat_t stat,
    output eoa_pkg::ctrl_t ctrl
);
    import eoa_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_RD_WAIT, ST_H_RD, ST_H_CHK,
        ST_T_RD, ST_T_WR, ST_O_RD, ST_O_CHK, ST_O_WR, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctrl         = '0;
        case (state_reg)
            ST_CLEAR: begin
                ctrl.clr = 1'b1;
                if (stat.sweep_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.cmd)
                    CMD_START: begin
                        if (stat.full) ctrl.set_no_slot = 1'b1;
                        else ctrl.slot_wr = 1'b1;
                        state_next = ST_FIN;
                    end
                    CMD_END: begin
                        ctrl.idx_clr = 1'b1;
                        state_next   = ST_H_RD;
                    end
                    CMD_RD_CELL: state_next = ST_RD_WAIT;
                    default:     state_next = ST_RD_WAIT;
                endcase
            end
            ST_RD_WAIT: begin
                ctrl.rd_take = 1'b1;
                state_next   = ST_FIN;
            end
            ST_H_RD: state_next = ST_H_CHK;
            ST_H_CHK: begin
                if (stat.idx_valid && stat.tag_hit) begin
                    ctrl.hit_take = 1'b1;
                    state_next    = ST_T_RD;
                end else if (stat.idx_last) begin
                    ctrl.set_no_end = 1'b1;
                    state_next      = ST_FIN;
                end else begin
                    ctrl.idx_inc = 1'b1;
                    state_next   = ST_H_RD;
                end
            end
            ST_T_RD: begin
                ctrl.cls_rsel_hit = 1'b1;
                state_next        = ST_T_WR;
            end
            ST_T_WR: begin
                ctrl.tot_wr  = 1'b1;
                ctrl.idx_clr = 1'b1;
                state_next   = ST_O_RD;
            end
            ST_O_RD: state_next = ST_O_CHK;
            ST_O_CHK: begin
                if (stat.idx_valid) begin
                    ctrl.ov_take        = 1'b1;
                    ctrl.cell_rsel_slot = 1'b1;
                    state_next          = ST_O_WR;
                end else if (stat.idx_last) begin
                    state_next = ST_FIN;
                end else begin
                    ctrl.idx_inc = 1'b1;
                    state_next   = ST_O_RD;
                end
            end
            ST_O_WR: begin
                ctrl.ov_wr = 1'b1;
                if (stat.idx_last) begin
                    state_next = ST_FIN;
                end else begin
                    ctrl.idx_inc = 1'b1;
                    state_next   = ST_O_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    ctrl.res_load = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

@@ hw/rtl/eoa_datapath.sv @@
// slot store, overlap and class total memories, accumulators and result register
// depends on eoa_pkg and eoa_ram
module eoa_datapath #(
    parameter int MAX_OPEN    = eoa_pkg::MAX_OPEN_DEF,
    parameter int NUM_CLASSES = eoa_pkg::NUM_CLASSES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  eoa_pkg::in_t   s_data,
    input  eoa_pkg::ctrl_t ctrl,
    output eoa_pkg::stat_t stat,
    output eoa_pkg::out_t  m_data
);
    import eoa_pkg::*;

    localparam int SW    = $clog2(MAX_OPEN);
    localparam int CW    = $clog2(NUM_CLASSES);
    localparam int CAW   = $clog2(NUM_CLASSES * NUM_CLASSES);
    localparam int SLW   = TAG_W + CW + TIME_W;
    localparam int NMAP  = 1 << FIELD_CLASS_W;

    // field value to class index, folded at elaboration
    logic [CW-1:0] cls_map [NMAP];
    for (genvar g = 0; g < NMAP; g++) begin : g_map
        assign cls_map[g] = CW'(g % NUM_CLASSES);
    end

    logic [1:0]        cmd_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CW-1:0]     cls_reg, oth_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SW-1:0]     idx_reg;
    logic [MAX_OPEN-1:0] valid_reg;
    logic [CAW-1:0]    sweep_reg;
    logic [CW-1:0]     hit_cls_reg;
    logic [TIME_W-1:0] hit_start_reg, dur_reg, added_reg, rd_reg, ov_reg;
    logic [TIME_W-1:0] grand_reg, ovtot_reg;
    logic [CAW-1:0]    cell_addr_reg;
    logic [1:0]        status_reg;
    out_t              res_reg;

    // slot memory
    logic [SLW-1:0]    slot_rdata;
    logic [TAG_W-1:0]  sl_tag;
    logic [CW-1:0]     sl_cls;
    logic [TIME_W-1:0] sl_start;
    logic [SW-1:0]     free_idx;
    assign {sl_tag, sl_cls, sl_start} = slot_rdata;

    always_comb begin
        free_idx = '0;
        for (int i = MAX_OPEN - 1; i >= 0; i--) begin
            if (!valid_reg[i]) free_idx = SW'(i);
        end
    end

    eoa_ram #(.WIDTH(SLW), .DEPTH(MAX_OPEN)) u_slot_ram (
        .aclk  (aclk),
        .we    (ctrl.slot_wr),
        .waddr (free_idx),
        .wdata ({tag_reg, cls_reg, now_reg}),
        .raddr (idx_reg),
        .rdata (slot_rdata)
    );

    // overlap term against the slot being read
    logic [TIME_W-1:0] later, ov;
    logic [CW-1:0]     lo, hi;
    logic [CAW-1:0]    ov_addr, rd_addr;
    assign later   = (sl_start > hit_start_reg) ? sl_start : hit_start_reg;
    assign ov      = now_reg - later;
    assign lo      = (hit_cls_reg < sl_cls) ? hit_cls_reg : sl_cls;
    assign hi      = (hit_cls_reg < sl_cls) ? sl_cls : hit_cls_reg;
    assign ov_addr = CAW'(int'(lo) * NUM_CLASSES + int'(hi));
    assign rd_addr = CAW'(int'(cls_reg) * NUM_CLASSES + int'(oth_reg));

    // overlap cell memory
    logic [TIME_W-1:0] cell_rdata;
    eoa_ram #(.WIDTH(TIME_W), .DEPTH(NUM_CLASSES * NUM_CLASSES)) u_cell_ram (
        .aclk  (aclk),
        .we    (ctrl.clr || ctrl.ov_wr),
        .waddr (ctrl.clr ? sweep_reg : cell_addr_reg),
        .wdata (ctrl.clr ? '0 : cell_rdata + ov_reg),
        .raddr (ctrl.cell_rsel_slot ? ov_addr : rd_addr),
        .rdata (cell_rdata)
    );

    // class total memory
    logic [TIME_W-1:0] cls_rdata;
    logic              cls_clr;
    assign cls_clr = ctrl.clr && (sweep_reg < CAW'(NUM_CLASSES));
    eoa_ram #(.WIDTH(TIME_W), .DEPTH(NUM_CLASSES)) u_cls_ram (
        .aclk  (aclk),
        .we    (cls_clr || ctrl.tot_wr),
        .waddr (ctrl.clr ? sweep_reg[CW-1:0] : hit_cls_reg),
        .wdata (ctrl.clr ? '0 : cls_rdata + dur_reg),
        .raddr (ctrl.cls_rsel_hit ? hit_cls_reg : cls_reg),
        .rdata (cls_rdata)
    );

    assign stat.cmd        = cmd_t'(cmd_reg);
    assign stat.full       = &valid_reg;
    assign stat.idx_last   = (idx_reg == SW'(MAX_OPEN - 1));
    assign stat.idx_valid  = valid_reg[idx_reg];
    assign stat.tag_hit    = (sl_tag == tag_reg);
    assign stat.sweep_done = (sweep_reg == CAW'(NUM_CLASSES * NUM_CLASSES - 1));
    assign m_data          = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            sweep_reg <= '0;
            grand_reg <= '0;
            ovtot_reg <= '0;
        end else begin
            if (ctrl.clr) sweep_reg <= sweep_reg + 1'b1;
            if (ctrl.slot_wr) valid_reg[free_idx] <= 1'b1;
            if (ctrl.hit_take) valid_reg[idx_reg] <= 1'b0;
            if (ctrl.tot_wr) grand_reg <= grand_reg + dur_reg;
            if (ctrl.ov_wr) ovtot_reg <= ovtot_reg + ov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg    <= s_data.cmd;
            tag_reg    <= s_data.event_tag;
            cls_reg    <= cls_map[s_data.event_class];
            oth_reg    <= cls_map[s_data.other_class];
            now_reg    <= s_data.instant;
            status_reg <= STATUS_OK;
            dur_reg    <= '0;
            added_reg  <= '0;
            rd_reg     <= '0;
        end
        if (ctrl.set_no_slot) status_reg <= STATUS_NO_SLOT;
        if (ctrl.set_no_end) status_reg <= STATUS_NO_END;
        if (ctrl.idx_clr) idx_reg <= '0;
        else if (ctrl.idx_inc) idx_reg <= idx_reg + 1'b1;
        if (ctrl.hit_take) begin
            hit_cls_reg   <= sl_cls;
            hit_start_reg <= sl_start;
            dur_reg       <= now_reg - sl_start;
        end
        if (ctrl.ov_take) begin
            ov_reg        <= ov;
            cell_addr_reg <= ov_addr;
        end
        if (ctrl.ov_wr) added_reg <= added_reg + ov_reg;
        if (ctrl.rd_take) begin
            rd_reg <= (cmd_t'(cmd_reg) == CMD_RD_CELL) ? cell_rdata : cls_rdata;
        end
        if (ctrl.res_load) begin
            res_reg.status         <= status_reg;
            res_reg.duration       <= dur_reg;
            res_reg.overlap_added  <= added_reg;
            res_reg.read_value     <= rd_reg;
            res_reg.total_time     <= grand_reg;
            res_reg.effective_time <= grand_reg - ovtot_reg;
        end
    end
endmodule
